// ===== design/smpt_pkg.sv =====
// Package for the serial mouse packet tracker: codes, widths and the job record
// passed from the front end to the back end. No dependencies.
`default_nettype none

package smpt_pkg;

	localparam int POS_W        = 16;
	localparam int DIV_W        = 13;
	localparam int BYTE_W       = 8;
	localparam int PACKET_LEN   = 5;
	localparam int COUNT_W      = 3;
	localparam int TIMEOUT_W    = 7;
	localparam int TIMEOUT_DEF  = 100;
	localparam int QUEUE_DEPTH  = 2;
	localparam int REG_IDX_W    = 3;
	localparam int CFG_W        = 16;

	localparam logic [1:0] CMD_SCAN   = 2'd0;
	localparam logic [1:0] CMD_RESUME = 2'd1;
	localparam logic [1:0] CMD_CALIB  = 2'd2;

	localparam logic [1:0] ST_NOTHING = 2'd0;
	localparam logic [1:0] ST_NEW     = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_RECT_LEFT   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_RECT_TOP    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RECT_RIGHT  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RECT_BOTTOM = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DIVIDE_X    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DIVIDE_Y    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_START_X     = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_START_Y     = 3'd7;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_APPLY,
		OP_CALIB
	} job_op_t;

	typedef struct packed {
		job_op_t                  op;
		logic [1:0]               status;
		logic                     prompt;
		logic [BYTE_W-1:0]        buttons;
		logic signed [POS_W-1:0]  dx;
		logic signed [POS_W-1:0]  dy;
	} job_t;

endpackage

`default_nettype wire

// ===== design/smpt_intf.sv =====
// Valid/ready channel interfaces for scan beats in and report beats out.
// Depends on smpt_pkg for field widths.
`default_nettype none

interface smpt_scan_if import smpt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       command;
	logic             byte_valid;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, command, byte_valid, rx_byte, input ready);
	modport sink   (input valid, command, byte_valid, rx_byte, output ready);
endinterface

interface smpt_report_if import smpt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic                    send_prompt;
	logic [BYTE_W-1:0]       button_bits;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;

	modport source (output valid, status, send_prompt, button_bits, pos_x, pos_y,
		input ready);
	modport sink   (input valid, status, send_prompt, button_bits, pos_x, pos_y,
		output ready);
endinterface

`default_nettype wire

// ===== design/smpt_div.sv =====
// Iterative restoring divider, signed 16-bit dividend by unsigned 13-bit divisor,
// truncating toward zero, one quotient bit per cycle. Depends on smpt_pkg.
`default_nettype none

module smpt_div import smpt_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [POS_W-1:0] dividend,
	input  wire logic [DIV_W-1:0]        divisor,
	output logic                         busy,
	output logic                         done,
	output logic signed [POS_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(POS_W);

	logic [POS_W-1:0] work_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvs_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;

	logic [DIV_W:0]   trial;
	logic             fits;
	logic [DIV_W:0]   diff;

	assign trial = {rem_q, work_q[POS_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(POS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend[POS_W-1] ? POS_W'(-dividend) : dividend;
			neg_q  <= dividend[POS_W-1];
			rem_q  <= '0;
			dvs_q  <= (divisor == '0) ? DIV_W'(1) : divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			work_q <= {work_q[POS_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? POS_W'(-work_q) : work_q;

endmodule

`default_nettype wire

// ===== design/smpt_queue.sv =====
// Short FIFO of jobs between the front and back ends.
// Depends on smpt_pkg for job_t and the queue depth.
`default_nettype none

module smpt_queue import smpt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output logic      not_empty,
	output job_t      head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("job queue underflow");

endmodule

`default_nettype wire

// ===== design/smpt_front.sv =====
// Front end: takes scan beats, collects packet bytes, runs the timeout count
// and turns each beat into one job. Depends on smpt_pkg and smpt_intf.
`default_nettype none

module smpt_front import smpt_pkg::*; #(
	parameter int TIMEOUT_LIMIT = TIMEOUT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	smpt_scan_if.sink  scan,
	input  wire logic  q_full,
	output logic       push,
	output job_t       push_job
);

	localparam logic [TIMEOUT_W-1:0] TMO_RELOAD = TIMEOUT_W'(TIMEOUT_LIMIT);

	logic [BYTE_W-1:0]    pkt_q [PACKET_LEN];
	logic [COUNT_W-1:0]   count_q;
	logic [TIMEOUT_W-1:0] tmo_q;
	logic                 accept;
	logic                 pkt_full;
	logic                 pkt_any;

	function automatic logic signed [POS_W-1:0] decode_delta(
		input logic [BYTE_W-1:0] hi,
		input logic [BYTE_W-1:0] lo
	);
		logic [POS_W-1:0] w;
		w = {2'b00, hi, 6'b000000} | {8'h00, lo};
		if (w[11])
			w[15:12] = 4'hF;
		return w;
	endfunction

	assign scan.ready = !q_full;
	assign accept     = scan.valid && !q_full;
	assign push       = accept;
	assign pkt_full   = count_q >= COUNT_W'(PACKET_LEN);

	always_comb begin
		pkt_any = 1'b0;
		for (int i = 0; i < PACKET_LEN; i++)
			pkt_any = pkt_any | (|pkt_q[i]);
	end

	always_comb begin
		push_job         = '0;
		push_job.op      = OP_NONE;
		push_job.status  = ST_NOTHING;
		push_job.buttons = pkt_q[0];
		push_job.dx      = decode_delta(pkt_q[2], pkt_q[1]);
		push_job.dy      = decode_delta(pkt_q[4], pkt_q[3]);
		unique case (scan.command)
			CMD_SCAN: begin
				if (pkt_full) begin
					push_job.prompt = 1'b1;
					if (pkt_any) begin
						push_job.op     = OP_APPLY;
						push_job.status = ST_NEW;
					end
				end else if (tmo_q == '0) begin
					push_job.status = ST_TIMEOUT;
				end
			end
			CMD_RESUME: push_job.prompt = 1'b1;
			CMD_CALIB: begin
				push_job.op     = OP_CALIB;
				push_job.prompt = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tmo_q   <= TMO_RELOAD;
			for (int i = 0; i < PACKET_LEN; i++)
				pkt_q[i] <= '0;
		end else if (accept) begin
			unique case (scan.command)
				CMD_SCAN: begin
					if (pkt_full) begin
						count_q <= '0;
						tmo_q   <= TMO_RELOAD;
						for (int i = 0; i < PACKET_LEN; i++)
							pkt_q[i] <= '0;
					end else if (tmo_q == '0) begin
						tmo_q <= TMO_RELOAD;
					end else if (scan.byte_valid) begin
						pkt_q[count_q] <= scan.rx_byte;
						count_q        <= count_q + 1'b1;
					end else begin
						tmo_q <= tmo_q - 1'b1;
					end
				end
				CMD_RESUME, CMD_CALIB: begin
					count_q <= '0;
					tmo_q   <= TMO_RELOAD;
					for (int i = 0; i < PACKET_LEN; i++)
						pkt_q[i] <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/smpt_back.sv =====
// Back end: configuration registers, cursor and button state, two dividers and
// the report output register. Depends on smpt_pkg, smpt_intf and smpt_div.
`default_nettype none

module smpt_back import smpt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [REG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0] wr_data,
	input  wire logic             q_not_empty,
	input  wire job_t             q_head,
	output logic                  pop,
	smpt_report_if.source         report
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_APPLY
	} state_t;

	typedef logic signed [POS_W:0] wide_t;

	state_t                  state_q;
	logic signed [POS_W-1:0] left_q, top_q, right_q, bottom_q;
	logic signed [POS_W-1:0] start_x_q, start_y_q;
	logic [DIV_W-1:0]        div_x_q, div_y_q;
	logic signed [POS_W-1:0] cur_x_q, cur_y_q;
	logic [BYTE_W-1:0]       btn_q;
	logic [BYTE_W-1:0]       pend_btn_q;
	logic signed [POS_W-1:0] qx_q, qy_q;

	logic                    out_valid_q;
	logic [1:0]              out_status_q;
	logic                    out_prompt_q;

	logic                    out_free;
	logic                    out_load;
	logic                    div_start;
	logic                    busy_x, busy_y, done_x, done_y;
	logic signed [POS_W-1:0] quo_x, quo_y;
	wide_t                   sum_x, sum_y, nx, ny;

	smpt_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (q_head.dx),
		.divisor  (div_x_q),
		.busy     (busy_x),
		.done     (done_x),
		.quotient (quo_x)
	);

	smpt_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (q_head.dy),
		.divisor  (div_y_q),
		.busy     (busy_y),
		.done     (done_y),
		.quotient (quo_y)
	);

	assign out_free  = !out_valid_q || report.ready;
	assign pop       = (state_q == S_IDLE) && q_not_empty && out_free;
	assign div_start = pop && (q_head.op == OP_APPLY);
	assign out_load  = (pop && (q_head.op != OP_APPLY)) || ((state_q == S_APPLY) && out_free);

	// new position at 17 bits, low bound first so the high bound wins
	always_comb begin
		sum_x = wide_t'(cur_x_q) + wide_t'(qx_q);
		sum_y = wide_t'(cur_y_q) - wide_t'(qy_q);
		nx = sum_x;
		if (nx < wide_t'(left_q))
			nx = wide_t'(left_q);
		if (nx > wide_t'(right_q))
			nx = wide_t'(right_q);
		ny = sum_y;
		if (ny < wide_t'(top_q))
			ny = wide_t'(top_q);
		if (ny > wide_t'(bottom_q))
			ny = wide_t'(bottom_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			top_q     <= '0;
			right_q   <= POS_W'(511);
			bottom_q  <= POS_W'(255);
			div_x_q   <= DIV_W'(2);
			div_y_q   <= DIV_W'(2);
			start_x_q <= '0;
			start_y_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RECT_LEFT:   left_q    <= wr_data;
				REG_RECT_TOP:    top_q     <= wr_data;
				REG_RECT_RIGHT:  right_q   <= wr_data;
				REG_RECT_BOTTOM: bottom_q  <= wr_data;
				REG_DIVIDE_X:    div_x_q   <= wr_data[DIV_W-1:0];
				REG_DIVIDE_Y:    div_y_q   <= wr_data[DIV_W-1:0];
				REG_START_X:     start_x_q <= wr_data;
				REG_START_Y:     start_y_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			btn_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_NOTHING;
			out_prompt_q <= 1'b0;
		end else begin
			if (out_valid_q && report.ready && !out_load)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (q_head.op == OP_APPLY) begin
							state_q <= S_DIV;
						end else begin
							if (q_head.op == OP_CALIB) begin
								cur_x_q <= start_x_q;
								cur_y_q <= start_y_q;
							end
							out_valid_q  <= 1'b1;
							out_status_q <= q_head.status;
							out_prompt_q <= q_head.prompt;
						end
					end
				end
				S_DIV: begin
					if (done_x)
						state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (out_free) begin
						cur_x_q      <= nx[POS_W-1:0];
						cur_y_q      <= ny[POS_W-1:0];
						btn_q        <= pend_btn_q;
						out_valid_q  <= 1'b1;
						out_status_q <= ST_NEW;
						out_prompt_q <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_start)
			pend_btn_q <= q_head.buttons;
		if (state_q == S_DIV && done_x) begin
			qx_q <= quo_x;
			qy_q <= quo_y;
		end
	end

	assign report.valid       = out_valid_q;
	assign report.status      = out_status_q;
	assign report.send_prompt = out_prompt_q;
	assign report.button_bits = btn_q;
	assign report.pos_x       = cur_x_q;
	assign report.pos_y       = cur_y_q;

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(done_x == done_y) && (busy_x == busy_y))
		else $error("x and y dividers out of step");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !busy_x)
		else $error("divider busy while back end idle");

	a_apply_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && out_free) |=> out_valid_q && out_status_q == ST_NEW)
		else $error("packet apply did not load a report");

endmodule

`default_nettype wire

// ===== design/serial_mouse_packet_tracker.sv =====
// Serial mouse packet tracker, top level: front end, job queue, back end.
// A scan beat goes through the job queue and the report register; a packet
// evaluation also runs the back end's 16-step dividers. Throughput, with
// report ready: one beat per cycle for beats that do not evaluate a packet.
// Reset (arst_n) restores the configuration registers, cursor and packet state at once.
// Depends on smpt_pkg, smpt_intf, smpt_front, smpt_queue, smpt_back.
`default_nettype none

module serial_mouse_packet_tracker import smpt_pkg::*; #(
	parameter int TIMEOUT_LIMIT = TIMEOUT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [REG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	smpt_scan_if.sink                 scan,
	smpt_report_if.source             report
);

	logic push, pop, q_full, q_not_empty;
	job_t push_job, q_head;

	smpt_front #(
		.TIMEOUT_LIMIT (TIMEOUT_LIMIT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan     (scan),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	smpt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	smpt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.report      (report)
	);

endmodule

`default_nettype wire
